FILE: rtl/core/triangle_point_to_barycentric_uv_top_defines.svh
// Assertion macros for the barycentric u/v block.
// Used by the port checker; no other dependencies.
`ifndef TRIANGLE_POINT_TO_BARYCENTRIC_UV_TOP_DEFINES_SVH
`define TRIANGLE_POINT_TO_BARYCENTRIC_UV_TOP_DEFINES_SVH

// same-cycle implication
`define TPBUV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPBUV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tpbuv_pkg.sv
// Shared widths, status codes and the front-to-divider payload type
// for the barycentric u/v block. No dependencies.
package tpbuv_pkg;

  localparam int CW = 32;               // coordinate width
  localparam int QW = 32;               // result width
  localparam int DW = CW + 1;           // edge vector width
  localparam int PW = 2 * DW;           // product width
  localparam int JW = PW + 2;           // cross-term width
  localparam int MW = JW - 1;           // cross-term magnitude width
  localparam int COORD_FRAC_BITS = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [MW-1:0] nmag_u;
    logic [MW-1:0] nmag_v;
    logic [MW-1:0] den;
    logic          neg_u;
    logic          neg_v;
    logic          degen;
  } tpbuv_num_t;

endpackage

FILE: rtl/core/tpbuv_front.sv
// Front pipeline: edge vectors, plane determinants, plane choice and
// Cramer numerators (8 stages). Depends on tpbuv_pkg.
module tpbuv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [tpbuv_pkg::CW-1:0] c0x, c0y, c0z,
  input  logic signed [tpbuv_pkg::CW-1:0] c1x, c1y, c1z,
  input  logic signed [tpbuv_pkg::CW-1:0] c2x, c2y, c2z,
  input  logic signed [tpbuv_pkg::CW-1:0] px, py, pz,
  output logic                           num_valid,
  input  logic                           num_ready,
  output tpbuv_pkg::tpbuv_num_t          num
);
  import tpbuv_pkg::*;

  logic [8:1] v;
  logic [8:1] rdy;

  logic signed [DW-1:0] a1 [3], b1 [3], d1 [3];
  logic signed [DW-1:0] a2 [3], b2 [3], d2 [3];
  logic signed [DW-1:0] a3 [3], b3 [3], d3 [3];
  logic signed [DW-1:0] a4 [3], b4 [3], d4 [3];
  logic signed [PW-1:0] pj2 [6];
  logic signed [JW-1:0] jv3 [3];
  logic [MW-1:0]        jm4 [3];
  logic [2:0]           jn4;
  logic signed [DW-1:0] di5, dj5, ai5, aj5, bi5, bj5;
  logic [MW-1:0]        den5, den6, den7, den8;
  logic                 dneg5, dneg6, dneg7;
  logic                 degen5, degen6, degen7, degen8;
  logic signed [PW-1:0] pn6 [4];
  logic signed [JW-1:0] nu7, nv7;
  logic [MW-1:0]        mu8, mv8;
  logic                 ngu8, ngv8;

  logic [1:0]           pl;
  logic signed [DW-1:0] di_n, dj_n, ai_n, aj_n, bi_n, bj_n;
  logic [MW-1:0]        den_n;
  logic                 dneg_n;

  assign rdy[8]   = !v[8] || num_ready;
  assign rdy[7:1] = ~v[7:1] | rdy[8:2];
  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // plane choice, later plane wins ties
  always_comb begin
    if (jm4[0] > jm4[1] && jm4[0] > jm4[2]) pl = 2'd0;
    else if (jm4[1] > jm4[2])               pl = 2'd1;
    else                                    pl = 2'd2;
    unique case (pl)
      2'd0: begin
        di_n = d4[0]; dj_n = d4[1]; ai_n = a4[0]; aj_n = a4[1];
        bi_n = b4[0]; bj_n = b4[1]; den_n = jm4[0]; dneg_n = jn4[0];
      end
      2'd1: begin
        di_n = d4[0]; dj_n = d4[2]; ai_n = a4[0]; aj_n = a4[2];
        bi_n = b4[0]; bj_n = b4[2]; den_n = jm4[1]; dneg_n = jn4[1];
      end
      default: begin
        di_n = d4[1]; dj_n = d4[2]; ai_n = a4[1]; aj_n = a4[2];
        bi_n = b4[1]; bj_n = b4[2]; den_n = jm4[2]; dneg_n = jn4[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      a1[0] <= DW'(c1x) - DW'(c0x);
      a1[1] <= DW'(c1y) - DW'(c0y);
      a1[2] <= DW'(c1z) - DW'(c0z);
      b1[0] <= DW'(c2x) - DW'(c0x);
      b1[1] <= DW'(c2y) - DW'(c0y);
      b1[2] <= DW'(c2z) - DW'(c0z);
      d1[0] <= DW'(px) - DW'(c0x);
      d1[1] <= DW'(py) - DW'(c0y);
      d1[2] <= DW'(pz) - DW'(c0z);
    end
    if (rdy[2]) begin
      pj2[0] <= PW'(a1[0]) * PW'(b1[1]);
      pj2[1] <= PW'(a1[1]) * PW'(b1[0]);
      pj2[2] <= PW'(a1[0]) * PW'(b1[2]);
      pj2[3] <= PW'(a1[2]) * PW'(b1[0]);
      pj2[4] <= PW'(a1[1]) * PW'(b1[2]);
      pj2[5] <= PW'(a1[2]) * PW'(b1[1]);
      a2 <= a1; b2 <= b1; d2 <= d1;
    end
    if (rdy[3]) begin
      jv3[0] <= JW'(pj2[0]) - JW'(pj2[1]);
      jv3[1] <= JW'(pj2[2]) - JW'(pj2[3]);
      jv3[2] <= JW'(pj2[4]) - JW'(pj2[5]);
      a3 <= a2; b3 <= b2; d3 <= d2;
    end
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        jm4[k] <= jv3[k][JW-1] ? MW'(-jv3[k]) : MW'(jv3[k]);
        jn4[k] <= jv3[k][JW-1];
      end
      a4 <= a3; b4 <= b3; d4 <= d3;
    end
    if (rdy[5]) begin
      di5 <= di_n; dj5 <= dj_n; ai5 <= ai_n; aj5 <= aj_n;
      bi5 <= bi_n; bj5 <= bj_n;
      den5 <= den_n; dneg5 <= dneg_n; degen5 <= (den_n == '0);
    end
    if (rdy[6]) begin
      pn6[0] <= PW'(di5) * PW'(bj5);
      pn6[1] <= PW'(dj5) * PW'(bi5);
      pn6[2] <= PW'(dj5) * PW'(ai5);
      pn6[3] <= PW'(di5) * PW'(aj5);
      den6 <= den5; dneg6 <= dneg5; degen6 <= degen5;
    end
    if (rdy[7]) begin
      nu7 <= JW'(pn6[0]) - JW'(pn6[1]);
      nv7 <= JW'(pn6[2]) - JW'(pn6[3]);
      den7 <= den6; dneg7 <= dneg6; degen7 <= degen6;
    end
    if (rdy[8]) begin
      mu8  <= nu7[JW-1] ? MW'(-nu7) : MW'(nu7);
      mv8  <= nv7[JW-1] ? MW'(-nv7) : MW'(nv7);
      ngu8 <= nu7[JW-1] ^ dneg7;
      ngv8 <= nv7[JW-1] ^ dneg7;
      den8 <= den7; degen8 <= degen7;
    end
  end

  assign num_valid    = v[8];
  assign num.nmag_u   = mu8;
  assign num.nmag_v   = mv8;
  assign num.den      = den8;
  assign num.neg_u    = ngu8;
  assign num.neg_v    = ngv8;
  assign num.degen    = degen8;

endmodule

FILE: rtl/core/tpbuv_div.sv
// Pipelined restoring divider for u and v, one quotient bit per stage,
// with sign, saturation and status. Depends on tpbuv_pkg.
module tpbuv_div #(
  parameter int FRAC_BITS = tpbuv_pkg::COORD_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          num_valid,
  output logic                          num_ready,
  input  tpbuv_pkg::tpbuv_num_t         num,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tpbuv_pkg::QW-1:0] u,
  output logic signed [tpbuv_pkg::QW-1:0] v,
  output logic [1:0]                    status
);
  import tpbuv_pkg::*;

  localparam int NW = MW + FRAC_BITS;
  localparam int XW = MW + QW;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] nlow;
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]   ln;
    logic [MW-1:0] den;
    logic          degen;
  } stg_t;

  stg_t        st [QW+1];
  stg_t        st_n [QW+1];
  logic [QW:0] sv;
  logic [QW:0] rdy;
  logic        rdy_o;

  logic [NW-1:0] n0 [2];

  assign rdy_o        = !out_valid || out_ready;
  assign rdy[QW]      = !sv[QW] || rdy_o;
  assign rdy[QW-1:0]  = ~sv[QW-1:0] | rdy[QW:1];
  assign num_ready    = rdy[0];

  // entry: split numerator, flag quotients of 2^QW or more
  always_comb begin
    n0[0] = {num.nmag_u, FRAC_BITS'(0)};
    n0[1] = {num.nmag_v, FRAC_BITS'(0)};
    st_n[0].den   = num.den;
    st_n[0].degen = num.degen;
    for (int k = 0; k < 2; k++) begin
      st_n[0].ln[k].rem  = MW'(n0[k] >> QW);
      st_n[0].ln[k].nlow = n0[k][QW-1:0];
      st_n[0].ln[k].q    = '0;
      st_n[0].ln[k].ovf  = XW'(n0[k]) >= {num.den, QW'(0)};
    end
    st_n[0].ln[0].neg = num.neg_u;
    st_n[0].ln[1].neg = num.neg_v;
  end

  genvar s;
  generate
    for (s = 1; s <= QW; s++) begin : g_step
      logic [MW:0] t [2];
      logic        ge [2];
      always_comb begin
        st_n[s] = st[s-1];
        for (int k = 0; k < 2; k++) begin
          t[k]  = {st[s-1].ln[k].rem, st[s-1].ln[k].nlow[QW-s]};
          ge[k] = t[k] >= {1'b0, st[s-1].den};
          st_n[s].ln[k].rem = ge[k] ? MW'(t[k] - {1'b0, st[s-1].den}) : MW'(t[k]);
          st_n[s].ln[k].q   = {st[s-1].ln[k].q[QW-2:0], ge[k]};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      if (rdy[0]) sv[0] <= num_valid;
      for (int k = 1; k <= QW; k++) begin
        if (rdy[k]) sv[k] <= sv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QW; k++) begin
      if (rdy[k]) st[k] <= st_n[k];
    end
  end

  // sign, saturation and status
  logic [QW-1:0] lim [2];
  logic [QW-1:0] res [2];
  logic          sat [2];
  logic [1:0]    status_n;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lim[k] = st[QW].ln[k].neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      sat[k] = st[QW].ln[k].ovf || (st[QW].ln[k].q > lim[k]);
      if (st[QW].degen)  res[k] = '0;
      else if (sat[k])   res[k] = lim[k];
      else               res[k] = st[QW].ln[k].neg ? -st[QW].ln[k].q : st[QW].ln[k].q;
    end
    if (st[QW].degen)          status_n = ST_DEGEN;
    else if (sat[0] || sat[1]) status_n = ST_SAT;
    else                       status_n = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= sv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      u      <= res[0];
      v      <= res[1];
      status <= status_n;
    end
  end

endmodule

FILE: rtl/core/triangle_point_to_barycentric_uv_top.sv
// Top level of the triangle point to barycentric u/v block.
// Depends on tpbuv_pkg, tpbuv_front and tpbuv_div.
//
// Takes one request per cycle unless stalled and returns one result per request, in
// order, through 8 front stages (edge vectors, 33x33 determinant products, plane
// choice, numerator products), one divider entry stage, 32 restoring-division
// stages (one quotient bit each, u and v side by side) and the output register.
// Throughput is one result per cycle when the output is not stalled. Each stage
// holds while the one after it is full and stalled, so bubbles close up under
// backpressure. A zero determinant gives u = v = 0 and status degenerate; an
// out-of-range quotient is clamped and status says saturated.
module triangle_point_to_barycentric_uv_top #(
  parameter int FRAC_BITS = tpbuv_pkg::COORD_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [tpbuv_pkg::CW-1:0] corner0_x,
  input  logic signed [tpbuv_pkg::CW-1:0] corner0_y,
  input  logic signed [tpbuv_pkg::CW-1:0] corner0_z,
  input  logic signed [tpbuv_pkg::CW-1:0] corner1_x,
  input  logic signed [tpbuv_pkg::CW-1:0] corner1_y,
  input  logic signed [tpbuv_pkg::CW-1:0] corner1_z,
  input  logic signed [tpbuv_pkg::CW-1:0] corner2_x,
  input  logic signed [tpbuv_pkg::CW-1:0] corner2_y,
  input  logic signed [tpbuv_pkg::CW-1:0] corner2_z,
  input  logic signed [tpbuv_pkg::CW-1:0] point_x,
  input  logic signed [tpbuv_pkg::CW-1:0] point_y,
  input  logic signed [tpbuv_pkg::CW-1:0] point_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [tpbuv_pkg::QW-1:0] coord_u,
  output logic signed [tpbuv_pkg::QW-1:0] coord_v,
  output logic [1:0]                     status
);
  import tpbuv_pkg::*;

  tpbuv_num_t num;
  logic       num_valid;
  logic       num_ready;

  tpbuv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .c0x       (corner0_x), .c0y (corner0_y), .c0z (corner0_z),
    .c1x       (corner1_x), .c1y (corner1_y), .c1z (corner1_z),
    .c2x       (corner2_x), .c2y (corner2_y), .c2z (corner2_z),
    .px        (point_x),   .py  (point_y),   .pz  (point_z),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num)
  );

  tpbuv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .u         (coord_u),
    .v         (coord_v),
    .status    (status)
  );

endmodule

FILE: rtl/core/tpbuv_checker.sv
// Port-level checks for the barycentric u/v block, bound to the top level.
// Depends on tpbuv_pkg and the defines header.
`include "triangle_point_to_barycentric_uv_top_defines.svh"

module tpbuv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [tpbuv_pkg::CW-1:0] corner0_x,
  input logic signed [tpbuv_pkg::CW-1:0] corner0_y,
  input logic signed [tpbuv_pkg::CW-1:0] corner0_z,
  input logic signed [tpbuv_pkg::CW-1:0] corner1_x,
  input logic signed [tpbuv_pkg::CW-1:0] corner1_y,
  input logic signed [tpbuv_pkg::CW-1:0] corner1_z,
  input logic signed [tpbuv_pkg::CW-1:0] corner2_x,
  input logic signed [tpbuv_pkg::CW-1:0] corner2_y,
  input logic signed [tpbuv_pkg::CW-1:0] corner2_z,
  input logic signed [tpbuv_pkg::CW-1:0] point_x,
  input logic signed [tpbuv_pkg::CW-1:0] point_y,
  input logic signed [tpbuv_pkg::CW-1:0] point_z,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [tpbuv_pkg::QW-1:0] coord_u,
  input logic signed [tpbuv_pkg::QW-1:0] coord_v,
  input logic [1:0]                     status
);
  import tpbuv_pkg::*;

  logic [12*CW-1:0] req_bits;

  assign req_bits = {corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
                     corner2_x, corner2_y, corner2_z, point_x, point_y, point_z};

  // waiting request holds
  `TPBUV_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(req_bits), "waiting request changed")

  // stalled result holds
  `TPBUV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coord_u) && $stable(coord_v) && $stable(status), "stalled result changed")

  `TPBUV_ASSERT_IMPL(a_status_code, out_valid, status == ST_OK || status == ST_DEGEN || status == ST_SAT, "bad status code")

  `TPBUV_ASSERT_IMPL(a_degen_zero, out_valid && status == ST_DEGEN, coord_u == 0 && coord_v == 0, "degenerate result not zero")

  `TPBUV_ASSERT_IMPL(a_sat_rail, out_valid && status == ST_SAT, coord_u == 32'sh7FFFFFFF || coord_u == 32'sh80000000 || coord_v == 32'sh7FFFFFFF || coord_v == 32'sh80000000, "saturated result off rail")

endmodule

bind triangle_point_to_barycentric_uv_top tpbuv_checker u_tpbuv_checker (.*);

FILE: dv/triangle_point_to_barycentric_uv_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_point_to_barycentric_uv_top: directed and random
// triangle/point requests, u/v/status predicted in 128-bit exact arithmetic.
// Depends on tpbuv_pkg and the RTL of the block only.
module triangle_point_to_barycentric_uv_top_tb;
  import tpbuv_pkg::*;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t tri_query_t[12];  // c0 xyz, c1 xyz, c2 xyz, point xyz
  typedef logic signed [127:0] wide_t;
  typedef logic [127:0] uwide_t;

  typedef struct {
    coord_t      u;
    coord_t      v;
    logic [1:0]  st;
  } uv_result_t;

  localparam int ONE = 1 << COORD_FRAC_BITS;

  logic   clk, rst;
  logic   in_valid, in_ready, out_valid, out_ready;
  coord_t coords[12];
  logic signed [QW-1:0] coord_u, coord_v;
  logic [1:0] status;

  uv_result_t expected_uv[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  triangle_point_to_barycentric_uv_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .corner0_x(coords[0]), .corner0_y(coords[1]), .corner0_z(coords[2]),
    .corner1_x(coords[3]), .corner1_y(coords[4]), .corner1_z(coords[5]),
    .corner2_x(coords[6]), .corner2_y(coords[7]), .corner2_z(coords[8]),
    .point_x(coords[9]), .point_y(coords[10]), .point_z(coords[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .coord_u(coord_u), .coord_v(coord_v), .status(status)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic coord_t clamp_quotient(wide_t num, wide_t den, inout bit sat);
    bit neg;
    uwide_t nm, dm, q, lim;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = (nm << COORD_FRAC_BITS) / dm;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1;
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic uv_result_t predict_uv(tri_query_t c);
    wide_t a[3], b[3], d[3], jv[3], o;
    uwide_t jm[3];
    int pl, i, j;
    bit sat;
    uv_result_t r;
    sat = 0;
    for (int k = 0; k < 3; k++) begin
      o = c[k];
      a[k] = c[3+k]; a[k] = a[k] - o;
      b[k] = c[6+k]; b[k] = b[k] - o;
      d[k] = c[9+k]; d[k] = d[k] - o;
    end
    jv[0] = a[0] * b[1] - a[1] * b[0];
    jv[1] = a[0] * b[2] - a[2] * b[0];
    jv[2] = a[1] * b[2] - a[2] * b[1];
    for (int k = 0; k < 3; k++) jm[k] = (jv[k] < 0) ? -jv[k] : jv[k];
    if (jm[0] > jm[1] && jm[0] > jm[2]) pl = 0;
    else if (jm[1] > jm[2]) pl = 1;
    else pl = 2;
    if (jm[pl] == 0) begin
      r.u = '0; r.v = '0; r.st = ST_DEGEN;
      return r;
    end
    i = (pl == 2) ? 1 : 0;
    j = (pl == 0) ? 1 : 2;
    r.u = clamp_quotient(d[i] * b[j] - d[j] * b[i], jv[pl], sat);
    r.v = clamp_quotient(d[j] * a[i] - d[i] * a[j], jv[pl], sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic send_request(tri_query_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    for (int k = 0; k < 12; k++) coords[k] = c[k];
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    expected_uv.push_back(predict_uv(c));
    @(negedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    uv_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_uv.size() == 0) begin
        $error("unexpected result u=%0h v=%0h status=%0d", coord_u, coord_v, status);
        errors++;
      end else begin
        e = expected_uv.pop_front();
        if (coord_u !== e.u) begin
          $error("coord_u expected %0h got %0h", e.u, coord_u); errors++;
        end
        if (coord_v !== e.v) begin
          $error("coord_v expected %0h got %0h", e.v, coord_v); errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status); errors++;
        end
      end
    end
  end

  function automatic tri_query_t small_triangle();
    tri_query_t c;
    for (int k = 0; k < 12; k++) c[k] = $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
    return c;
  endfunction

  function automatic tri_query_t full_random();
    tri_query_t c;
    for (int k = 0; k < 12; k++) c[k] = $urandom;
    return c;
  endfunction

  function automatic tri_query_t collinear();
    tri_query_t c;
    coord_t e;
    int m;
    m = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      e = $signed($urandom_range(0, 2000)) - 1000;
      c[k] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      c[3+k] = c[k] + e * ONE / 8;
      c[6+k] = c[k] + e * m * ONE / 8;
      c[9+k] = $urandom;
    end
    return c;
  endfunction

  function automatic tri_query_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return small_triangle();
    if (pick < 80) return full_random();
    if (pick < 90) return collinear();
    begin
      tri_query_t c;
      c = small_triangle();
      for (int k = 0; k < 3; k++) c[6+k] = c[3+k] + $signed($urandom_range(0, 3)) - 1;
      return c;
    end
  endfunction

  task automatic test_extremes();
    tri_query_t c;
    coord_t vals[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
    for (int n = 0; n < 8; n++) begin
      for (int k = 0; k < 12; k++) c[k] = vals[(k + n * 5 + k / 3) % 4];
      send_request(c);
    end
    for (int k = 0; k < 12; k++) c[k] = 32'sh8000_0000;
    c[3] = 32'sh7FFF_FFFF; c[7] = 32'sh7FFF_FFFF; c[11] = 32'sh7FFF_FFFF;
    send_request(c);
  endtask

  task automatic test_planes_and_ties();
    tri_query_t c;
    // xy dominant, point inside
    c = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE / 4, ONE / 4, 0};
    send_request(c);
    // xz dominant
    c = '{0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE / 2, 3, ONE / 3};
    send_request(c);
    // yz dominant
    c = '{0, 0, 0, 0, ONE, 0, 0, 0, ONE, 5, -ONE, 2 * ONE};
    send_request(c);
    // tie xy = xz goes to xz
    c = '{ONE, ONE, ONE, 2 * ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 0, 0, 0};
    send_request(c);
    // tie xy = xz (opposite signs)
    c = '{0, 0, 0, ONE, 0, 0, 0, ONE, -ONE, ONE, ONE, ONE};
    send_request(c);
    // tie xz = yz goes to yz
    c = '{0, 0, 0, 0, 0, ONE, ONE, ONE, 0, ONE, -ONE, ONE};
    send_request(c);
    // all three equal
    c = '{0, 0, 0, ONE, 0, -ONE, 0, ONE, ONE, 7, 9, 11};
    send_request(c);
  endtask

  task automatic test_degenerate_and_saturation();
    tri_query_t c;
    c = '{3, 4, 5, 3, 4, 5, 3, 4, 5, 1, 2, 3};
    send_request(c);
    c = '{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0};
    send_request(c);
    // tiny triangle, far point: both signs saturate
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
    send_request(c);
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0};
    send_request(c);
    // v exactly on the negative limit, u one past the positive limit
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32'sh0000_8000, -32'sh0000_8000, 0};
    send_request(c);
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_request(random_item());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    repeat (80) send_request(random_item());
  endtask

  task automatic test_drain_pause();
    in_valid = 0;
    wait (expected_uv.size() == 0);
    repeat (50) @(negedge clk);
    test_random(60, 10, 10);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    for (int k = 0; k < 12; k++) coords[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_extremes();
    test_planes_and_ties();
    test_degenerate_and_saturation();
    test_random(300, 0, 0);
    test_random(300, 46, 0);
    test_random(300, 0, 46);
    test_random(300, 29, 29);
    test_backpressure();
    test_drain_pause();
    test_random(100, 20, 20);
    in_valid = 0;
    wait (expected_uv.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
